// ===== rtl/ilid_pkg.sv =====
// Package for the indexed list insert/delete block.
// Opcodes, status codes, state encoding, command struct and widths.
// No dependencies.
`default_nettype none

package ilid_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 7;
    localparam int OP_W          = 3;
    localparam int STAT_W        = 2;
    localparam int CNT_OUT_W     = 7;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 48;
    localparam int CAPACITY_DEF  = 64;

    localparam logic [OP_W-1:0] OP_GET  = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

    localparam logic [STAT_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    // datapath command for one accepted request
    typedef struct packed {
        logic ld;
        logic rd;
        logic ins;
        logic del;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/indexed_list_insert_delete.sv =====
// Top level of the indexed list insert/delete block.
// Joins ilid_ctrl and ilid_dp. Depends on ilid_pkg.
//
// Channel  Dir  Fields (tdata, lsb first)
// s        in   opcode[2:0], position[9:3], item_value[41:10]
// m        out  read_value[31:0], status[33:32], entry_count[40:34]
//
// A result is valid the cycle after its request; all shift cells move at once.
// A request is taken each cycle as long as the output register is free or drained.
// Reset clears the count and the handshake state; cell contents are left as is.
// A stalled output holds its result and blocks further requests.
`default_nettype none

module indexed_list_insert_delete import ilid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // opcode, position, item_value, zero pad
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // read_value, status, entry_count, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_cmd                 w_cmd;
    logic [IDX_W-1:0]     w_pos;
    logic [DATA_W-1:0]    w_read_value;
    logic [STAT_W-1:0]    w_status;
    logic [CNT_OUT_W-1:0] w_entry_count;

    ilid_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_opcode      (i_s_tdata[2:0]),
        .i_position    (i_s_tdata[9:3]),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_status      (w_status),
        .o_entry_count (w_entry_count),
        .o_cmd         (w_cmd),
        .o_pos         (w_pos)
    );

    ilid_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_pos        (w_pos),
        .i_value      (i_s_tdata[41:10]),
        .o_read_value (w_read_value)
    );

    assign o_m_tdata = {7'd0, w_entry_count, w_status, w_read_value};

endmodule

`default_nettype wire

// ===== rtl/ilid_dp.sv =====
// Datapath: chain of shift cells holding the list, plus the read register.
// Depends on ilid_pkg.
`default_nettype none

module ilid_dp import ilid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire               i_clk,
    input  wire t_cmd         i_cmd,
    input  wire [IDX_W-1:0]   i_pos,
    input  wire [DATA_W-1:0]  i_value,
    output logic [DATA_W-1:0] o_read_value
);

    logic [DATA_W-1:0] r_cell [CAPACITY];
    logic [DATA_W-1:0] n_cell [CAPACITY];
    logic [DATA_W-1:0] r_read;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_comb begin
            n_cell[i] = r_cell[i];
            if (i_cmd.ins) begin
                if (IDX_W'(i) == i_pos) begin
                    n_cell[i] = i_value;
                end else if (i > 0 && IDX_W'(i) > i_pos) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.del) begin
                if (i < CAPACITY - 1 && IDX_W'(i) >= i_pos) begin
                    n_cell[i] = r_cell[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            if (i_cmd.rd) begin
                r_read <= r_cell[i_pos];
            end else begin
                r_read <= '1;
            end
        end
    end

    assign o_read_value = r_read;

endmodule

`default_nettype wire

// ===== rtl/ilid_ctrl.sv =====
// Controller: decodes requests, checks ranges, keeps the entry count and
// the output handshake state. Depends on ilid_pkg.
`default_nettype none

module ilid_ctrl import ilid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [OP_W-1:0]       i_opcode,
    input  wire [POS_W-1:0]      i_position,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [CNT_OUT_W-1:0] o_entry_count,
    output t_cmd                 o_cmd,
    output logic [IDX_W-1:0]     o_pos
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STAT_W-1:0]   r_status, n_status;
    logic                w_accept;
    logic [CMP_W-1:0]    w_posx, w_cntx, w_ipos;
    logic                w_lt, w_gt, w_full;
    logic                w_rd, w_ins, w_del;

    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == S_RESP);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_posx = CMP_W'(i_position);
    assign w_cntx = CMP_W'(r_count);
    assign w_lt   = w_posx < w_cntx;
    assign w_gt   = w_posx > w_cntx;
    assign w_full = r_count == CNT_W'(CAPACITY);

    always_comb begin
        w_rd     = 1'b0;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_ipos   = w_posx;
        n_status = STS_DONE;
        case (i_opcode)
            OP_GET: begin
                if (w_lt) w_rd = 1'b1;
                else      n_status = STS_RANGE;
            end
            OP_HEAD: begin
                w_ipos = '0;
                if (w_full) n_status = STS_FULL;
                else        w_ins = 1'b1;
            end
            OP_TAIL: begin
                w_ipos = w_cntx;
                if (w_full) n_status = STS_FULL;
                else        w_ins = 1'b1;
            end
            OP_AT: begin
                if (w_gt)        n_status = STS_RANGE;
                else if (w_full) n_status = STS_FULL;
                else             w_ins = 1'b1;
            end
            OP_DEL: begin
                if (w_lt) w_del = 1'b1;
                else      n_status = STS_RANGE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_accept && w_ins)      n_count = r_count + 1'b1;
        else if (w_accept && w_del) n_count = r_count - 1'b1;
    end

    always_comb begin
        n_state = r_state;
        if (w_accept)         n_state = S_RESP;
        else if (i_out_ready) n_state = S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_status <= n_status;
    end

    assign o_cmd.ld  = w_accept;
    assign o_cmd.rd  = w_accept && w_rd;
    assign o_cmd.ins = w_accept && w_ins;
    assign o_cmd.del = w_accept && w_del;
    assign o_pos     = w_ipos[IDX_W-1:0];

    assign o_status      = r_status;
    assign o_entry_count = w_cntx[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/ilid_chk.sv =====
// Port-level checker for indexed_list_insert_delete, bound to the top level.
// Depends on ilid_pkg.
`default_nettype none

module ilid_chk import ilid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_TDATA_W-1:0] o_m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("request without result");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[33:32] != 2'd3)
        else $error("bad status code");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[33:32] == STS_FULL |->
        o_m_tdata[31:0] == '1 && o_m_tdata[40:34] == CNT_OUT_W'(CAPACITY))
        else $error("full status with wrong result");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (CAPACITY > 127) || (int'(o_m_tdata[40:34]) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind indexed_list_insert_delete ilid_chk #(.CAPACITY(CAPACITY)) u_ilid_chk (.*);

`default_nettype wire

// ===== bench/indexed_list_insert_delete_tb.sv =====
// Self-checking bench for indexed_list_insert_delete: directed edges, fill/drain and random mix.
// Keeps its own copy of the list, predicts every response and compares it with the block.
// Depends on ilid_pkg and the block's RTL.
`timescale 1ns / 100ps

module indexed_list_insert_delete_tb;
    import ilid_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int MAX_PRINTED = 100;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [DATA_W-1:0] NO_READ      = '1;
    localparam logic [POS_W-1:0] POS_TOP       = '1;

    localparam int READY_ALWAYS  = 0;
    localparam int READY_PATTERN = 1;
    localparam int READY_SPARSE  = 2;

    typedef struct packed {
        logic [DATA_W-1:0]    read_value;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_list_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // opcode, position, item_value, zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // read_value, status, entry_count, zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // model of the list
    logic [DATA_W-1:0] list_cells [0:LIST_DEPTH-1];
    int                list_len = 0;

    t_list_result pending_results [$];
    t_list_result want_result;
    t_list_result got_result;
    int           mismatch_count = 0;

    // sender burst shaping and receiver stall pattern
    int          gap_max = 0;
    int          burst_max = 8;
    int          burst_left = 0;
    int          ready_mode = READY_ALWAYS;
    logic [31:0] stall_pattern = 32'hF0F3_A5C7;
    logic [5:0]  stall_age = '0;

    indexed_list_insert_delete #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        stall_age <= stall_age + 1'b1;
        if (stall_age == '0) begin
            stall_pattern <= $urandom;
        end else begin
            stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
        end
        case (ready_mode)
            READY_ALWAYS: begin
                i_m_tready <= 1'b1;
            end
            READY_PATTERN: begin
                i_m_tready <= stall_pattern[0];
            end
            default: begin
                i_m_tready <= stall_pattern[0] & stall_pattern[9];
            end
        endcase
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic logic [STAT_W-1:0] insert_entry(input int p, input logic [DATA_W-1:0] v);
        if (list_len >= LIST_DEPTH) begin
            return STS_FULL;
        end
        for (int i = list_len; i > p; i--) begin
            list_cells[i] = list_cells[i-1];
        end
        list_cells[p] = v;
        list_len++;
        return STS_DONE;
    endfunction

    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        t_list_result r;
        r.read_value = NO_READ;
        r.status     = STS_DONE;
        case (op)
            OP_GET: begin
                if (int'(pos) < list_len) begin
                    r.read_value = list_cells[pos];
                end else begin
                    r.status = STS_RANGE;
                end
            end
            OP_HEAD: begin
                r.status = insert_entry(0, val);
            end
            OP_TAIL: begin
                r.status = insert_entry(list_len, val);
            end
            OP_AT: begin
                if (int'(pos) > list_len) begin
                    r.status = STS_RANGE;
                end else begin
                    r.status = insert_entry(int'(pos), val);
                end
            end
            OP_DEL: begin
                if (int'(pos) < list_len) begin
                    for (int i = int'(pos); i + 1 < list_len; i++) begin
                        list_cells[i] = list_cells[i+1];
                    end
                    list_len--;
                end else begin
                    r.status = STS_RANGE;
                end
            end
            default: ;
        endcase
        r.entry_count = list_len[CNT_OUT_W-1:0];
        return r;
    endfunction

    // drives one request, waits for it to be taken, then records the expected response
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, burst_max);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - DATA_W - POS_W - OP_W){1'b0}}, val, pos, op};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_result.read_value  = o_m_tdata[DATA_W-1:0];
            got_result.status      = o_m_tdata[DATA_W +: STAT_W];
            got_result.entry_count = o_m_tdata[DATA_W + STAT_W +: CNT_OUT_W];
            if (pending_results.size() == 0) begin
                report_mismatch("response with no request pending");
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.read_value !== want_result.read_value) begin
                    report_mismatch($sformatf("read_value %h, want %h",
                                              got_result.read_value, want_result.read_value));
                end
                if (got_result.status !== want_result.status) begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got_result.status, want_result.status));
                end
                if (got_result.entry_count !== want_result.entry_count) begin
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              got_result.entry_count, want_result.entry_count));
                end
            end
        end
    end

    function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
        int span;
        int r;
        r = $urandom_range(0, 99);
        span = (op == OP_AT) ? list_len : list_len - 1;
        if (r < 15 || span < 0) begin
            return $urandom_range(0, POS_TOP);
        end
        if (r < 25) begin
            return list_len;
        end
        return $urandom_range(0, span);
    endfunction

    function automatic logic [OP_W-1:0] pick_opcode(input int ins_w, input int del_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
        end
        if (r < 3 + ins_w) begin
            case ($urandom_range(0, 2))
                0: return OP_HEAD;
                1: return OP_TAIL;
                default: return OP_AT;
            endcase
        end
        if (r < 3 + ins_w + del_w) begin
            return OP_DEL;
        end
        return OP_GET;
    endfunction

    task automatic send_random(input int ins_w, input int del_w);
        logic [OP_W-1:0] op;
        op = pick_opcode(ins_w, del_w);
        send_request(op, pick_position(op), $urandom);
    endtask

    task automatic set_idling(input int gap, input int burst, input int mode);
        gap_max    = gap;
        burst_max  = burst;
        ready_mode = mode;
    endtask

    task automatic test_directed_edges();
        set_idling(0, 4, READY_ALWAYS);
        send_request(OP_GET, 0, 32'h0);
        send_request(OP_DEL, 0, 32'h0);
        send_request(OP_AT, 1, 32'h1);
        send_request(OP_AT, POS_TOP, 32'h2);
        send_request(OP_AT, 0, 32'h7FFF_FFFF);
        send_request(OP_HEAD, POS_TOP, 32'h8000_0000);
        send_request(OP_TAIL, 0, 32'h0000_0000);
        send_request(OP_TAIL, 0, 32'hFFFF_FFFF);
        send_request(OP_AT, 2, 32'h1234_5678);
        send_request(OP_GET, 0, 32'hFFFF_FFFF);
        send_request(OP_GET, 2, 32'h0);
        send_request(OP_GET, list_len - 1, 32'h0);
        send_request(OP_GET, list_len, 32'h0);
        send_request(OP_GET, POS_TOP, 32'h0);
        send_request(OP_DEL, POS_TOP, 32'h0);
        send_request(OP_AT, list_len + 1, 32'h5555_AAAA);
        send_request(OP_AT, list_len, 32'hAAAA_5555);
        send_request(OP_DEL, 0, 32'h0);
        send_request(OP_DEL, list_len - 1, 32'h0);
        send_request(OP_DEL, 1, 32'h0);
        send_request(OP_SPARE_FIRST, POS_TOP, 32'hFFFF_FFFF);
        send_request(OP_SPARE_FIRST + 1, 0, $urandom);
        send_request(OP_SPARE_LAST, 1, $urandom);
        send_request(OP_GET, 1, 32'h0);
    endtask

    // fills the list to capacity, hammers the full case, then empties it
    task automatic test_fill_and_drain();
        while (list_len < LIST_DEPTH) begin
            send_random(85, 2);
        end
        send_request(OP_HEAD, 0, $urandom);
        send_request(OP_TAIL, 0, $urandom);
        send_request(OP_AT, LIST_DEPTH, $urandom);
        send_request(OP_AT, LIST_DEPTH + 1, $urandom);
        send_request(OP_AT, 0, $urandom);
        send_request(OP_GET, LIST_DEPTH - 1, 32'h0);
        send_request(OP_GET, LIST_DEPTH, 32'h0);
        repeat (8) send_random(80, 0);
        while (list_len > 0) begin
            send_random(5, 80);
        end
        send_request(OP_DEL, 0, 32'h0);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_random(45, 30);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();

        set_idling(3, 12, READY_PATTERN);
        test_fill_and_drain();

        set_idling(0, 64, READY_ALWAYS);
        test_random_mix(40);

        set_idling(12, 6, READY_SPARSE);
        test_fill_and_drain();

        set_idling(4, 16, READY_PATTERN);
        test_random_mix(60);

        i_s_tvalid <= 1'b0;
        while (pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[indexed_list_insert_delete] OK");
        end else begin
            $display("[indexed_list_insert_delete] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[indexed_list_insert_delete] ERROR");
        $finish;
    end

endmodule
